// ===== rtl/core/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg: shared constants and types for the ray / rectangle slab test
// Default field widths, fixed-point format, register indexes and reset values.
// ----------------------------------------------------------------------------
package rrs_pkg;

  // default field widths
  localparam int COORD_WIDTH = 32;
  localparam int PARAM_WIDTH = 48;

  // fraction bits of the Q formats
  localparam int FRAC_BITS = 16;

  // parallel threshold register width
  localparam int THR_WIDTH = 17;

  // configuration register index width
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_FAR       = 1'b1
  } cfg_reg_t;

  localparam logic [THR_WIDTH-1:0] THR_RESET = 17'd1;
  localparam logic [63:0]          FAR_RESET = 64'd65536000000;

endpackage

// ===== rtl/core/rrs_in_if.sv =====
// ----------------------------------------------------------------------------
// rrs_in_if: request channel of the slab test
// Rectangle, ray origin and ray direction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrs_in_if #(
  parameter int CW = rrs_pkg::COORD_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] rect_left;
  logic signed [CW-1:0] rect_top;
  logic        [CW-2:0] rect_width;
  logic        [CW-2:0] rect_height;
  logic signed [CW-1:0] origin_x;
  logic signed [CW-1:0] origin_y;
  logic signed [CW-1:0] dir_x;
  logic signed [CW-1:0] dir_y;

  modport source (
    output valid, rect_left, rect_top, rect_width, rect_height,
           origin_x, origin_y, dir_x, dir_y,
    input  ready
  );

  modport sink (
    input  valid, rect_left, rect_top, rect_width, rect_height,
           origin_x, origin_y, dir_x, dir_y,
    output ready
  );
endinterface

// ===== rtl/core/rrs_out_if.sv =====
// ----------------------------------------------------------------------------
// rrs_out_if: result channel of the slab test
// Hit flag, interval bounds and contact point with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrs_out_if #(
  parameter int CW = rrs_pkg::COORD_WIDTH,
  parameter int PW = rrs_pkg::PARAM_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic signed [PW-1:0] u_enter;
  logic signed [PW-1:0] u_exit;
  logic signed [CW-1:0] contact_x;
  logic signed [CW-1:0] contact_y;

  modport source (
    output valid, hit, u_enter, u_exit, contact_x, contact_y,
    input  ready
  );

  modport sink (
    input  valid, hit, u_enter, u_exit, contact_x, contact_y,
    output ready
  );
endinterface

// ===== rtl/core/ray_rect_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_rect_slab_intersect: 2-D ray versus axis-aligned rectangle slab test
//
// ray_in carries one request per handshake: rectangle left/top/width/height,
// ray origin and direction, all Q16.16. result returns one item per request,
// in order: hit, entry and exit parameters (Q32.16, saturated) and the
// contact point origin + dir * entry (Q16.16, saturated, zero on a miss).
// cfg_we/cfg_index/cfg_data write the parallel threshold (index 0) and the
// far limit (index 1); write them only while no request is in flight.
//
// The pipeline has COORD_WIDTH + 24 register stages (56 at defaults): two
// front stages, one stage per quotient bit of the four parallel dividers,
// then sort, x narrowing, y narrowing, multiply and contact add/saturate,
// the last of which is the output register.
// Throughput is one request per cycle. The whole pipeline advances together:
// when result is valid and not taken, every stage holds and ray_in.ready
// drops; nothing is lost or repeated. Reset clears all stage valid bits and
// returns the registers to threshold 1 and far limit one million.
// ----------------------------------------------------------------------------
module ray_rect_slab_intersect #(
  parameter int COORD_WIDTH = rrs_pkg::COORD_WIDTH,
  parameter int PARAM_WIDTH = rrs_pkg::PARAM_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  rrs_in_if.sink                            ray_in,
  rrs_out_if.source                         result,
  input  logic                              cfg_we,
  input  logic [rrs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [PARAM_WIDTH-2:0]            cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int PW   = PARAM_WIDTH;
  localparam int FB   = rrs_pkg::FRAC_BITS;
  localparam int TW   = rrs_pkg::THR_WIDTH;
  localparam int EW   = CW + 1;
  localparam int DFW  = CW + 2;
  localparam int NW   = CW + 1 + FB;
  localparam int LAT  = NW + 7;
  localparam int MW   = (CW > TW) ? CW : TW;
  localparam int XW   = ((NW > PW) ? NW : PW) + 1;
  localparam int SW   = 8 + 4 * CW;
  localparam int UHW  = PW - 1 - FB;
  localparam int P1W  = CW + UHW + 1;
  localparam int P2W  = CW + FB + 1;
  localparam int SUMW = P1W + 1;

  localparam logic [XW-1:0]          Q_POS_MAX = (XW'(1) << (PW - 1)) - XW'(1);
  localparam logic signed [PW-1:0]   T_MAX     = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0]   T_MIN     = {1'b1, {(PW-1){1'b0}}};
  localparam logic signed [SUMW-1:0] C_MAX     = SUMW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SUMW-1:0] C_MIN     = -C_MAX - SUMW'(1);

  // configuration registers
  logic [TW-1:0] thr;
  logic [PW-2:0] far;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= rrs_pkg::THR_RESET;
      far <= (PW-1)'(rrs_pkg::FAR_RESET);
    end else if (cfg_we) begin
      case (rrs_pkg::cfg_reg_t'(cfg_index))
        rrs_pkg::REG_THRESHOLD: thr <= cfg_data[TW-1:0];
        rrs_pkg::REG_FAR:       far <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: hold everything while the result waits
  logic           en;
  logic [LAT-1:0] vld;

  assign en           = !vld[LAT-1] || result.ready;
  assign ray_in.ready = en;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], ray_in.valid};
    end
  end

  // stage 1: capture request, form right and bottom edges
  logic signed [EW-1:0] s1_lo_x, s1_hi_x, s1_lo_y, s1_hi_y;
  logic signed [CW-1:0] s1_ox, s1_oy, s1_dx, s1_dy;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_lo_x <= EW'(ray_in.rect_left);
      s1_hi_x <= EW'(ray_in.rect_left) + $signed(EW'(ray_in.rect_width));
      s1_lo_y <= EW'(ray_in.rect_top);
      s1_hi_y <= EW'(ray_in.rect_top) + $signed(EW'(ray_in.rect_height));
      s1_ox   <= ray_in.origin_x;
      s1_oy   <= ray_in.origin_y;
      s1_dx   <= ray_in.dir_x;
      s1_dy   <= ray_in.dir_y;
    end
  end

  // stage 2: edge offsets, magnitudes, quotient signs, parallel checks
  logic signed [DFW-1:0] dlx, dhx, dly, dhy;
  logic [CW-1:0]         adx, ady;
  logic [DFW-1:0]        mlx, mhx, mly, mhy;
  logic                  par_x, par_y, in_x, in_y;

  always_comb begin
    dlx   = DFW'(s1_lo_x) - DFW'(s1_ox);
    dhx   = DFW'(s1_hi_x) - DFW'(s1_ox);
    dly   = DFW'(s1_lo_y) - DFW'(s1_oy);
    dhy   = DFW'(s1_hi_y) - DFW'(s1_oy);
    mlx   = dlx[DFW-1] ? DFW'(-dlx) : DFW'(dlx);
    mhx   = dhx[DFW-1] ? DFW'(-dhx) : DFW'(dhx);
    mly   = dly[DFW-1] ? DFW'(-dly) : DFW'(dly);
    mhy   = dhy[DFW-1] ? DFW'(-dhy) : DFW'(dhy);
    adx   = s1_dx[CW-1] ? CW'(-s1_dx) : CW'(s1_dx);
    ady   = s1_dy[CW-1] ? CW'(-s1_dy) : CW'(s1_dy);
    par_x = (s1_dx == '0) || (MW'(adx) < MW'(thr));
    par_y = (s1_dy == '0) || (MW'(ady) < MW'(thr));
    in_x  = !((EW'(s1_ox) < s1_lo_x) || (EW'(s1_ox) > s1_hi_x));
    in_y  = !((EW'(s1_oy) < s1_lo_y) || (EW'(s1_oy) > s1_hi_y));
  end

  logic [NW-1:0] s2_nlx, s2_nhx, s2_nly, s2_nhy;
  logic [CW-1:0] s2_adx, s2_ady;
  logic [SW-1:0] s2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_nlx  <= {mlx[CW:0], {FB{1'b0}}};
      s2_nhx  <= {mhx[CW:0], {FB{1'b0}}};
      s2_nly  <= {mly[CW:0], {FB{1'b0}}};
      s2_nhy  <= {mhy[CW:0], {FB{1'b0}}};
      s2_adx  <= adx;
      s2_ady  <= ady;
      s2_side <= {dlx[DFW-1] ^ s1_dx[CW-1], dhx[DFW-1] ^ s1_dx[CW-1],
                  dly[DFW-1] ^ s1_dy[CW-1], dhy[DFW-1] ^ s1_dy[CW-1],
                  par_x, par_y, in_x, in_y,
                  s1_ox, s1_oy, s1_dx, s1_dy};
    end
  end

  // divider bank: four slab parameters in parallel
  logic [NW-1:0] q [4];
  logic [SW-1:0] d_side;

  rrs_div_pipe #(.NW(NW), .DW(CW)) u_div_lx (
    .clk(clk), .en(en), .num(s2_nlx), .den(s2_adx), .quo(q[0]));
  rrs_div_pipe #(.NW(NW), .DW(CW)) u_div_hx (
    .clk(clk), .en(en), .num(s2_nhx), .den(s2_adx), .quo(q[1]));
  rrs_div_pipe #(.NW(NW), .DW(CW)) u_div_ly (
    .clk(clk), .en(en), .num(s2_nly), .den(s2_ady), .quo(q[2]));
  rrs_div_pipe #(.NW(NW), .DW(CW)) u_div_hy (
    .clk(clk), .en(en), .num(s2_nhy), .den(s2_ady), .quo(q[3]));

  rrs_delay #(.WIDTH(SW), .DEPTH(NW)) u_side (
    .clk(clk), .en(en), .d(s2_side), .q(d_side));

  logic [3:0]           d_neg;
  logic                 d_par_x, d_par_y, d_in_x, d_in_y;
  logic signed [CW-1:0] d_ox, d_oy, d_dx, d_dy;

  assign {d_neg, d_par_x, d_par_y, d_in_x, d_in_y, d_ox, d_oy, d_dx, d_dy} = d_side;

  // stage 3: apply sign, saturate and sort each slab pair
  logic signed [PW-1:0] t [4];

  for (genvar k = 0; k < 4; k++) begin : g_sat
    logic [XW-1:0] qe;
    always_comb begin
      qe = XW'(q[k]);
      if (!d_neg[3-k]) begin
        t[k] = (qe > Q_POS_MAX) ? T_MAX : PW'(qe);
      end else begin
        t[k] = (qe > Q_POS_MAX + XW'(1)) ? T_MIN : PW'(XW'(0) - qe);
      end
    end
  end

  logic signed [PW-1:0] s3_tlx, s3_thx, s3_tly, s3_thy;
  logic                 s3_par_x, s3_par_y, s3_in_x, s3_in_y;
  logic signed [CW-1:0] s3_ox, s3_oy, s3_dx, s3_dy;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tlx   <= (t[0] > t[1]) ? t[1] : t[0];
      s3_thx   <= (t[0] > t[1]) ? t[0] : t[1];
      s3_tly   <= (t[2] > t[3]) ? t[3] : t[2];
      s3_thy   <= (t[2] > t[3]) ? t[2] : t[3];
      s3_par_x <= d_par_x;
      s3_par_y <= d_par_y;
      s3_in_x  <= d_in_x;
      s3_in_y  <= d_in_y;
      s3_ox    <= d_ox;
      s3_oy    <= d_oy;
      s3_dx    <= d_dx;
      s3_dy    <= d_dy;
    end
  end

  // stage 4: narrow [0, far] by the x slab
  logic signed [PW-1:0] far_s;
  logic signed [PW-1:0] u0x, u1x;
  logic                 okx;

  assign far_s = $signed({1'b0, far});

  always_comb begin
    if (s3_par_x) begin
      u0x = '0;
      u1x = far_s;
      okx = s3_in_x;
    end else begin
      u0x = (s3_tlx > PW'(0)) ? s3_tlx : PW'(0);
      u1x = (s3_thx < far_s) ? s3_thx : far_s;
      okx = (u0x <= u1x);
    end
  end

  logic signed [PW-1:0] s4_u0, s4_u1, s4_tly, s4_thy;
  logic                 s4_okx, s4_par_y, s4_in_y;
  logic signed [CW-1:0] s4_ox, s4_oy, s4_dx, s4_dy;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_u0    <= u0x;
      s4_u1    <= u1x;
      s4_okx   <= okx;
      s4_tly   <= s3_tly;
      s4_thy   <= s3_thy;
      s4_par_y <= s3_par_y;
      s4_in_y  <= s3_in_y;
      s4_ox    <= s3_ox;
      s4_oy    <= s3_oy;
      s4_dx    <= s3_dx;
      s4_dy    <= s3_dy;
    end
  end

  // stage 5: narrow by the y slab unless x already missed
  logic signed [PW-1:0] u0y, u1y;
  logic                 hit_y;

  always_comb begin
    u0y   = s4_u0;
    u1y   = s4_u1;
    hit_y = 1'b0;
    if (s4_okx) begin
      if (s4_par_y) begin
        hit_y = s4_in_y;
      end else begin
        u0y   = (s4_tly > s4_u0) ? s4_tly : s4_u0;
        u1y   = (s4_thy < s4_u1) ? s4_thy : s4_u1;
        hit_y = (u0y <= u1y);
      end
    end
  end

  logic signed [PW-1:0] s5_u0, s5_u1;
  logic                 s5_hit;
  logic signed [CW-1:0] s5_ox, s5_oy, s5_dx, s5_dy;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_u0  <= u0y;
      s5_u1  <= u1y;
      s5_hit <= hit_y;
      s5_ox  <= s4_ox;
      s5_oy  <= s4_oy;
      s5_dx  <= s4_dx;
      s5_dy  <= s4_dy;
    end
  end

  // stage 6: direction times entry, integer and fraction parts
  logic signed [UHW:0]  uhi;
  logic signed [FB:0]   ulo;
  logic signed [P1W-1:0] s6_p1x, s6_p1y;
  logic signed [P2W-1:0] s6_p2x, s6_p2y;
  logic signed [PW-1:0]  s6_u0, s6_u1;
  logic                  s6_hit;
  logic signed [CW-1:0]  s6_ox, s6_oy;

  assign uhi = $signed({1'b0, s5_u0[PW-2:FB]});
  assign ulo = $signed({1'b0, s5_u0[FB-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      s6_p1x <= P1W'(s5_dx * uhi);
      s6_p1y <= P1W'(s5_dy * uhi);
      s6_p2x <= P2W'(s5_dx * ulo);
      s6_p2y <= P2W'(s5_dy * ulo);
      s6_u0  <= s5_u0;
      s6_u1  <= s5_u1;
      s6_hit <= s5_hit;
      s6_ox  <= s5_ox;
      s6_oy  <= s5_oy;
    end
  end

  // stage 7: add origin, saturate, zero on a miss
  logic signed [SUMW-1:0] sum_x, sum_y;
  logic signed [CW-1:0]   cx, cy;

  always_comb begin
    sum_x = SUMW'(s6_ox) + SUMW'(s6_p1x) + SUMW'(s6_p2x >>> FB);
    sum_y = SUMW'(s6_oy) + SUMW'(s6_p1y) + SUMW'(s6_p2y >>> FB);
    cx = (sum_x > C_MAX) ? CW'(C_MAX) : (sum_x < C_MIN) ? CW'(C_MIN) : CW'(sum_x);
    cy = (sum_y > C_MAX) ? CW'(C_MAX) : (sum_y < C_MIN) ? CW'(C_MIN) : CW'(sum_y);
  end

  logic                 o_hit;
  logic signed [PW-1:0] o_u0, o_u1;
  logic signed [CW-1:0] o_cx, o_cy;

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit <= s6_hit;
      o_u0  <= s6_u0;
      o_u1  <= s6_u1;
      o_cx  <= s6_hit ? cx : '0;
      o_cy  <= s6_hit ? cy : '0;
    end
  end

  assign result.hit       = o_hit;
  assign result.u_enter   = o_u0;
  assign result.u_exit    = o_u1;
  assign result.contact_x = o_cx;
  assign result.contact_y = o_cy;

endmodule

// ===== rtl/core/rrs_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rrs_div_pipe: pipelined unsigned restoring divider
// One quotient bit per stage, NW stages, one new division per enabled cycle.
// ----------------------------------------------------------------------------
module rrs_div_pipe #(
  parameter int NW = 49,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [DW-1:0] rem_q [NW-1];
  logic [NW-1:0] num_q [NW-1];
  logic [DW-1:0] den_q [NW-1];
  logic [NW-1:0] quo_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [NW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_next;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_mid
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    // shift in the next dividend bit and try the subtract
    always_comb begin
      trial    = {rem_in, num_in[NW-1]};
      ge       = (trial >= {1'b0, den_in});
      rem_next = ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[s] <= {quo_in[NW-2:0], ge};
      end
    end

    // carry partial remainder and operands to the next stage
    if (s < NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[s] <= rem_next;
          num_q[s] <= {num_in[NW-2:0], 1'b0};
          den_q[s] <= den_in;
        end
      end
    end
  end

  assign quo = quo_q[NW-1];

endmodule

// ===== rtl/core/rrs_delay.sv =====
// ----------------------------------------------------------------------------
// rrs_delay: enabled shift line
// Carries side data alongside the divider stages.
// ----------------------------------------------------------------------------
module rrs_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  // advance the line on enable
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

// ===== rtl/core/rrs_checker.sv =====
// ----------------------------------------------------------------------------
// rrs_checker: port-level checks for the slab test
// Result hold under stall, miss/hit consistency, ready and reset behavior.
// ----------------------------------------------------------------------------
module rrs_checker #(
  parameter int CW = rrs_pkg::COORD_WIDTH,
  parameter int PW = rrs_pkg::PARAM_WIDTH
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 hit,
  input logic signed [PW-1:0] u_enter,
  input logic signed [PW-1:0] u_exit,
  input logic signed [CW-1:0] contact_x,
  input logic signed [CW-1:0] contact_y
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(u_enter)
      && $stable(u_exit) && $stable(contact_x) && $stable(contact_y))
    else $error("stalled result changed");

  // a miss reports no contact point
  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> contact_x == '0 && contact_y == '0)
    else $error("contact nonzero on a miss");

  // a hit has a non-empty interval starting at or after the origin
  a_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> u_enter >= 0 && u_enter <= u_exit)
    else $error("hit with bad interval");

  // drop request ready only behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("request ready low without output stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ray_rect_slab_intersect rrs_checker #(
  .CW(COORD_WIDTH),
  .PW(PARAM_WIDTH)
) u_rrs_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(ray_in.ready),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .hit(result.hit),
  .u_enter(result.u_enter),
  .u_exit(result.u_exit),
  .contact_x(result.contact_x),
  .contact_y(result.contact_y)
);

// ===== verif/ray_rect_slab_intersect_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_rect_slab_intersect_tb: self-checking bench for the 2-D ray/rect test
// Drives rectangle and ray requests with random gaps and result stalls,
// predicts each hit, interval and contact point with an in-bench slab model,
// and compares every returned result in order. Sweeps threshold and far limit.
// ----------------------------------------------------------------------------
module ray_rect_slab_intersect_tb;

  localparam int  CW         = rrs_pkg::COORD_WIDTH;
  localparam int  PW         = rrs_pkg::PARAM_WIDTH;
  localparam int  LATENCY    = CW + 24;
  localparam int  STALL_LIMIT = 4000;
  localparam longint PMAX    = (64'sd1 <<< (PW - 1)) - 1;
  localparam longint PMIN    = -PMAX - 1;
  localparam longint CMAX    = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN    = -CMAX - 1;
  localparam longint ONE     = 64'sd65536;

  typedef struct {
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] top;
    logic        [CW-2:0] width;
    logic        [CW-2:0] height;
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
  } ray_req_t;

  typedef struct {
    logic                 hit;
    logic signed [PW-1:0] u_enter;
    logic signed [PW-1:0] u_exit;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
  } slab_res_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [rrs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [PW-2:0] cfg_data;

  rrs_in_if  ray_in ();
  rrs_out_if result ();

  ray_rect_slab_intersect u_dut (
    .clk       (clk),
    .rst       (rst),
    .ray_in    (ray_in),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers
  logic [rrs_pkg::THR_WIDTH-1:0] thr_reg;
  logic [PW-2:0]                 far_reg;

  slab_res_t hit_q[$];
  int        err_cnt;
  int        idle_cycles;
  bit        quiet;      // no gaps or stalls in this stretch
  bit        hold_req;   // ask the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // narrow [u0, u1] by one slab; return 0 on a miss for this axis
  function automatic bit narrow_slab(longint lo, longint hi, longint org, longint d,
                                     inout longint u0, inout longint u1);
    longint mag, t1, t2, s;
    mag = (d < 0) ? -d : d;
    if (d == 0 || mag < longint'(thr_reg))
      return !(org < lo || org > hi);
    t1 = clamp(((lo - org) * ONE) / d, PMIN, PMAX);
    t2 = clamp(((hi - org) * ONE) / d, PMIN, PMAX);
    if (t1 > t2) begin
      s = t1; t1 = t2; t2 = s;
    end
    if (t1 > u0) u0 = t1;
    if (t2 < u1) u1 = t2;
    return u0 <= u1;
  endfunction

  // origin + floor(dir * u / 1.0), saturated
  function automatic longint contact_at(longint org, longint d, longint u);
    longint prod;
    prod = d * (u >>> 16) + ((d * (u & 64'shFFFF)) >>> 16);
    return clamp(org + prod, CMIN, CMAX);
  endfunction

  function automatic slab_res_t predict_slab(ray_req_t r);
    slab_res_t e;
    longint l, t, ox, oy, dx, dy, u0, u1;
    l  = longint'(r.left);
    t  = longint'(r.top);
    ox = longint'(r.ox);
    oy = longint'(r.oy);
    dx = longint'(r.dx);
    dy = longint'(r.dy);
    u0 = 0;
    u1 = longint'(far_reg);
    e.hit = 1'b0;
    e.cx  = '0;
    e.cy  = '0;
    if (narrow_slab(l, l + longint'(r.width), ox, dx, u0, u1) &&
        narrow_slab(t, t + longint'(r.height), oy, dy, u0, u1)) begin
      e.hit = 1'b1;
      e.cx  = CW'(contact_at(ox, dx, u0));
      e.cy  = CW'(contact_at(oy, dy, u0));
    end
    e.u_enter = u0[PW-1:0];
    e.u_exit  = u1[PW-1:0];
    return e;
  endfunction

  // offer one request after a random gap and hold it until taken
  task automatic send_req(input ray_req_t r, input bit known, input slab_res_t k);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      ray_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ray_in.valid       <= 1'b1;
    ray_in.rect_left   <= r.left;
    ray_in.rect_top    <= r.top;
    ray_in.rect_width  <= r.width;
    ray_in.rect_height <= r.height;
    ray_in.origin_x    <= r.ox;
    ray_in.origin_y    <= r.oy;
    ray_in.dir_x       <= r.dx;
    ray_in.dir_y       <= r.dy;
    do @(posedge clk); while (!ray_in.ready);
    hit_q.push_back(known ? k : predict_slab(r));
  endtask

  // drop valid and wait until every result is back
  task automatic drain;
    ray_in.valid <= 1'b0;
    @(posedge clk);
    wait (hit_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input rrs_pkg::cfg_reg_t idx, input logic [PW-2:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == rrs_pkg::REG_THRESHOLD) thr_reg = val[rrs_pkg::THR_WIDTH-1:0];
    else far_reg = val;
  endtask

  function automatic ray_req_t mk(longint l, longint t, longint w, longint h,
                                  longint ox, longint oy, longint dx, longint dy);
    ray_req_t r;
    r.left = CW'(l); r.top = CW'(t); r.width = (CW-1)'(w); r.height = (CW-1)'(h);
    r.ox = CW'(ox); r.oy = CW'(oy); r.dx = CW'(dx); r.dy = CW'(dy);
    return r;
  endfunction

  // a plausible ray toward a nearby box, or raw noise
  function automatic ray_req_t rand_req();
    ray_req_t r;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      r.left = CW'($urandom); r.top = CW'($urandom);
      r.width = (CW-1)'($urandom); r.height = (CW-1)'($urandom);
      r.ox = CW'($urandom); r.oy = CW'($urandom);
      r.dx = CW'($urandom); r.dy = CW'($urandom);
    end else begin
      r.left   = CW'($signed($urandom_range(0, 200)) * ONE - 100 * ONE
                     + $urandom_range(0, 65535));
      r.top    = CW'($signed($urandom_range(0, 200)) * ONE - 100 * ONE
                     + $urandom_range(0, 65535));
      r.width  = (CW-1)'($urandom_range(0, 60) * ONE + $urandom_range(0, 65535));
      r.height = (CW-1)'($urandom_range(0, 60) * ONE + $urandom_range(0, 65535));
      r.ox     = CW'($signed($urandom_range(0, 300)) * ONE - 150 * ONE
                     + $urandom_range(0, 65535));
      r.oy     = CW'($signed($urandom_range(0, 300)) * ONE - 150 * ONE
                     + $urandom_range(0, 65535));
      r.dx     = CW'($signed($urandom_range(0, 8 * 65536)) - 4 * ONE);
      r.dy     = CW'($signed($urandom_range(0, 8 * 65536)) - 4 * ONE);
      // near-parallel directions around the threshold
      if (sel == 8) r.dx = CW'($signed($urandom_range(0, 2 * thr_reg + 2)) - thr_reg - 1);
      if (sel == 9) r.dy = CW'($signed($urandom_range(0, 2 * thr_reg + 2)) - thr_reg - 1);
    end
    return r;
  endfunction

  // result side: random stalls, one long hold-off on request, in-order check
  initial begin
    slab_res_t e;
    int n;
    bit hold_done;
    hold_done = 1'b0;
    result.ready = 1'b0;
    wait (!rst);
    forever begin
      if (hold_req && !hold_done) begin
        n = 400;
        hold_done = 1'b1;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 8);
      end
      if (n > 0) begin
        result.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b", $time, result.hit);
        err_cnt++;
      end else begin
        e = hit_q.pop_front();
        if (result.hit !== e.hit) begin
          $display("%0t: hit exp %0b got %0b", $time, e.hit, result.hit);
          err_cnt++;
        end
        if (result.u_enter !== e.u_enter) begin
          $display("%0t: u_enter exp %0d got %0d", $time, e.u_enter, result.u_enter);
          err_cnt++;
        end
        if (result.u_exit !== e.u_exit) begin
          $display("%0t: u_exit exp %0d got %0d", $time, e.u_exit, result.u_exit);
          err_cnt++;
        end
        if (result.contact_x !== e.cx) begin
          $display("%0t: contact_x exp %0d got %0d", $time, e.cx, result.contact_x);
          err_cnt++;
        end
        if (result.contact_y !== e.cy) begin
          $display("%0t: contact_y exp %0d got %0d", $time, e.cy, result.contact_y);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (ray_in.valid && ray_in.ready) || (result.valid && result.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("ray_rect_slab_intersect_tb NOT OK");
      $finish;
    end
  end

  // main sequence
  initial begin
    ray_req_t  dir_rows[$];
    bit        dir_known[$];
    slab_res_t dir_exp[$];
    slab_res_t k;
    slab_res_t none;
    ray_req_t  r;
    int        ph;
    none = '{1'b0, '0, '0, '0, '0};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = rrs_pkg::REG_THRESHOLD;
    cfg_data = '0;
    ray_in.valid = 1'b0;
    ray_in.rect_left = '0;
    ray_in.rect_top = '0;
    ray_in.rect_width = '0;
    ray_in.rect_height = '0;
    ray_in.origin_x = '0;
    ray_in.origin_y = '0;
    ray_in.dir_x = '0;
    ray_in.dir_y = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    thr_reg = rrs_pkg::THR_RESET;
    far_reg = rrs_pkg::FAR_RESET[PW-2:0];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: still ray inside the box, still ray outside the box
    k = '{1'b1, '0, 48'sd65536000000, 32'sd327680, 32'sd327680};
    dir_rows.push_back(mk(0, 0, 10 * ONE, 10 * ONE, 5 * ONE, 5 * ONE, 0, 0));
    dir_known.push_back(1); dir_exp.push_back(k);
    k = '{1'b0, '0, 48'sd65536000000, '0, '0};
    dir_rows.push_back(mk(0, 0, 10 * ONE, 10 * ONE, 20 * ONE, 5 * ONE, 0, 0));
    dir_known.push_back(1); dir_exp.push_back(k);
    // y outside while x parallel inside
    dir_rows.push_back(mk(0, 0, 10 * ONE, 10 * ONE, 5 * ONE, -ONE, 0, 0));
    // plain hits along each axis and diagonally, both directions along x
    dir_rows.push_back(mk(0, 0, 10 * ONE, 10 * ONE, -5 * ONE, 5 * ONE, ONE, 0));
    dir_rows.push_back(mk(0, 0, 10 * ONE, 10 * ONE, 15 * ONE, 5 * ONE, -ONE, 0));
    dir_rows.push_back(mk(0, 0, 10 * ONE, 10 * ONE, 5 * ONE, -5 * ONE, 0, 2 * ONE));
    dir_rows.push_back(mk(0, 0, 10 * ONE, 10 * ONE, -3 * ONE, -4 * ONE, ONE, ONE));
    // pointing away: interval empties
    dir_rows.push_back(mk(0, 0, 10 * ONE, 10 * ONE, -5 * ONE, 5 * ONE, -ONE, 0));
    // diagonal miss: slabs do not overlap
    dir_rows.push_back(mk(0, 0, ONE, ONE, -5 * ONE, 0, ONE, -ONE));
    // direction of one raw unit: not parallel at threshold one, saturates
    dir_rows.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                          32'sh7FFF_FFFF, 0, 1, 0));
    dir_rows.push_back(mk(0, 0, ONE, ONE, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1));
    // field extremes
    dir_rows.push_back(mk(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                          32'sh8000_0000, 32'sh8000_0000,
                          32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    dir_rows.push_back(mk(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                          32'sh8000_0000, 32'sh7FFF_FFFF,
                          32'sh8000_0000, 32'sh8000_0000));
    dir_rows.push_back(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0,
                          32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0));
    dir_rows.push_back(mk(-ONE, -ONE, 2 * ONE, 2 * ONE, 32'sh8000_0000, 0,
                          32'sh7FFF_FFFF, 3));
    // contact saturation with a large entry parameter
    dir_rows.push_back(mk(32'sh7000_0000, 0, 31'h0FFF_FFFF, 31'h7FFF_FFFF,
                          32'sh8000_0000, 32'sh7FFF_0000, 2, 32'sh7FFF_FFFF));
    // zero-size box hit exactly at the corner
    dir_rows.push_back(mk(ONE, ONE, 0, 0, 0, 0, ONE, ONE));
    foreach (dir_rows[i])
      send_req(dir_rows[i], dir_known[i], dir_known[i] ? dir_exp[i] : none);
    drain();

    // random phases over several register settings
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(rrs_pkg::REG_THRESHOLD, (PW-1)'(0));
          write_reg(rrs_pkg::REG_FAR, 47'h7FFF_FFFF_FFFF);
        end
        1: begin
          write_reg(rrs_pkg::REG_THRESHOLD, (PW-1)'(65536));
          write_reg(rrs_pkg::REG_FAR, (PW-1)'(0));
        end
        2: begin
          write_reg(rrs_pkg::REG_THRESHOLD, (PW-1)'($urandom_range(0, 65536)));
          write_reg(rrs_pkg::REG_FAR, (PW-1)'({$urandom, $urandom}));
        end
        3: begin
          write_reg(rrs_pkg::REG_THRESHOLD, (PW-1)'($urandom_range(1, 300)));
          write_reg(rrs_pkg::REG_FAR, (PW-1)'($urandom_range(1, 200) * ONE));
        end
        4: begin
          write_reg(rrs_pkg::REG_THRESHOLD, (PW-1)'(17'h1_FFFF));
          write_reg(rrs_pkg::REG_FAR, rrs_pkg::FAR_RESET[PW-2:0]);
        end
        default: begin
          write_reg(rrs_pkg::REG_THRESHOLD, (PW-1)'(rrs_pkg::THR_RESET));
          write_reg(rrs_pkg::REG_FAR, rrs_pkg::FAR_RESET[PW-2:0]);
        end
      endcase
      // long result hold-off against a full-rate sender
      if (ph == 1) begin
        quiet = 1'b1;
        hold_req = 1'b1;
        repeat (120) send_req(rand_req(), 1'b0, none);
        quiet = 1'b0;
      end
      for (int i = 0; i < 270; i++) begin
        if (i % 90 == 0) quiet = ($urandom_range(0, 2) == 0);
        r = rand_req();
        send_req(r, 1'b0, none);
      end
      quiet = 1'b0;
      drain();
    end

    if (err_cnt == 0)
      $display("ray_rect_slab_intersect_tb OK");
    else
      $display("ray_rect_slab_intersect_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rrs_pkg.sv
rtl/core/rrs_in_if.sv
rtl/core/rrs_out_if.sv
rtl/core/rrs_div_pipe.sv
rtl/core/rrs_delay.sv
rtl/core/ray_rect_slab_intersect.sv
rtl/core/rrs_checker.sv
verif/ray_rect_slab_intersect_tb.sv
